// File: design/ppcex_pkg.sv
// shared types, opcodes and helpers for the integer execute unit
`timescale 1ns / 1ps
package ppcex_pkg;

    localparam int unsigned XLEN   = 32;
    localparam int unsigned NREGS  = 32;
    localparam int unsigned RIDX_W = 5;
    localparam int unsigned OUT_W  = 72;

    localparam logic [31:0] CA_BIT   = 32'h2000_0000;
    localparam logic [31:0] SO_BIT   = 32'h8000_0000;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    // primary opcodes
    localparam logic [5:0] OP_MULLI   = 6'd7;
    localparam logic [5:0] OP_SUBFIC  = 6'd8;
    localparam logic [5:0] OP_CMPLI   = 6'd10;
    localparam logic [5:0] OP_CMPI    = 6'd11;
    localparam logic [5:0] OP_ADDIC   = 6'd12;
    localparam logic [5:0] OP_ADDICR  = 6'd13;
    localparam logic [5:0] OP_ADDI    = 6'd14;
    localparam logic [5:0] OP_ADDIS   = 6'd15;
    localparam logic [5:0] OP_RLWIMI  = 6'd20;
    localparam logic [5:0] OP_RLWINM  = 6'd21;
    localparam logic [5:0] OP_ORI     = 6'd24;
    localparam logic [5:0] OP_ORIS    = 6'd25;
    localparam logic [5:0] OP_XORI    = 6'd26;
    localparam logic [5:0] OP_XORIS   = 6'd27;
    localparam logic [5:0] OP_ANDI    = 6'd28;
    localparam logic [5:0] OP_ANDIS   = 6'd29;
    localparam logic [5:0] OP_EXT     = 6'd31;

    // extended opcodes under primary 31
    localparam logic [9:0] XO_CMP    = 10'd0;
    localparam logic [9:0] XO_MULHWU = 10'd11;
    localparam logic [9:0] XO_MFCR   = 10'd19;
    localparam logic [9:0] XO_SLW    = 10'd24;
    localparam logic [9:0] XO_CNTLZW = 10'd26;
    localparam logic [9:0] XO_AND    = 10'd28;
    localparam logic [9:0] XO_CMPL   = 10'd32;
    localparam logic [9:0] XO_SUBF   = 10'd40;
    localparam logic [9:0] XO_ANDC   = 10'd60;
    localparam logic [9:0] XO_MULHW  = 10'd75;
    localparam logic [9:0] XO_NEG    = 10'd104;
    localparam logic [9:0] XO_NOR    = 10'd124;
    localparam logic [9:0] XO_MTCRF  = 10'd144;
    localparam logic [9:0] XO_MULLW  = 10'd235;
    localparam logic [9:0] XO_ADD    = 10'd266;
    localparam logic [9:0] XO_EQV    = 10'd284;
    localparam logic [9:0] XO_XOR    = 10'd316;
    localparam logic [9:0] XO_MFSPR  = 10'd339;
    localparam logic [9:0] XO_ORC    = 10'd412;
    localparam logic [9:0] XO_OR     = 10'd444;
    localparam logic [9:0] XO_DIVWU  = 10'd459;
    localparam logic [9:0] XO_MTSPR  = 10'd467;
    localparam logic [9:0] XO_NAND   = 10'd476;
    localparam logic [9:0] XO_DIVW   = 10'd491;
    localparam logic [9:0] XO_SRW    = 10'd536;
    localparam logic [9:0] XO_SRAW   = 10'd792;
    localparam logic [9:0] XO_SRAWI  = 10'd824;
    localparam logic [9:0] XO_EXTSH  = 10'd922;
    localparam logic [9:0] XO_EXTSB  = 10'd954;

    localparam logic [9:0] SPR_XER = 10'd1;
    localparam logic [9:0] SPR_LR  = 10'd8;
    localparam logic [9:0] SPR_CTR = 10'd9;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture instruction, read operands
        logic exec;     // evaluate non-divide ops / start divide
        logic div_step; // one divide iteration
        logic commit;   // write state and result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_div;
        logic div_done;
    } t_status;

    function automatic logic [31:0] put_field(input logic [31:0] crv, input logic [2:0] fld,
                                              input logic [3:0] code);
        logic [31:0] m;
        logic [31:0] v;
        m = 32'hF000_0000 >> {fld, 2'b00};
        v = {code, 28'd0} >> {fld, 2'b00};
        return (crv & ~m) | v;
    endfunction

    function automatic logic [3:0] cmp_code(input logic [31:0] a, input logic [31:0] b,
                                            input logic sgn, input logic so);
        logic [31:0] x;
        logic [31:0] y;
        x = sgn ? (a ^ SO_BIT) : a;
        y = sgn ? (b ^ SO_BIT) : b;
        return {(x < y), (x > y), (x == y), so};
    endfunction

endpackage

// File: design/ppc_integer_execute_unit_top.sv
// top level of the powerpc integer execute unit
`timescale 1ns / 1ps
// Executes one 32-bit PowerPC integer instruction per input transfer.
// Input: s_axis_tdata carries the raw instruction word.
// Output: one result transfer per instruction on m_axis, tdata packed
// from bit 0: status, dest_valid, dest_index, dest_value, cond_reg,
// carry_flag, 72 bits in all.
// Sequence: operand read, execute, commit, then the result is presented;
// divw/divwu insert the 32 iterations of the radix-2 divider between
// execute and commit.
// Only one instruction is in flight at a time.
// A new instruction is accepted in the same cycle the previous result
// is taken, so back-to-back items see the committed state.
// Reset clears the register file, CR, XER, LR and CTR at once; no sweep.
// If the receiver stalls, the result holds and no new input is taken.
module ppc_integer_execute_unit_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // instruction_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status, dest_valid, dest_index[5], dest_value[32], cond_reg[32], carry_flag
    output logic [71:0] m_axis_tdata
);

    ppcex_pkg::t_cmd    w_cmd;
    ppcex_pkg::t_status w_status;

    ppcex_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_tvalid  (s_axis_tvalid),
        .o_in_tready  (s_axis_tready),
        .o_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .i_status     (w_status),
        .o_cmd        (w_cmd)
    );

    ppcex_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_instr  (s_axis_tdata),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_result (m_axis_tdata)
    );

endmodule

// File: design/ppcex_ctrl.sv
// controller state machine for the integer execute unit
`timescale 1ns / 1ps
module ppcex_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_tvalid,
    output logic              o_in_tready,
    output logic              o_out_tvalid,
    input  logic              i_out_tready,
    input  ppcex_pkg::t_status i_status,
    output ppcex_pkg::t_cmd   o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_DIV  = 5'b00100,
        S_DONE = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_tready = 1'b0;
        o_out_tvalid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_tready = 1'b1;
                if (i_in_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = i_status.is_div ? S_DIV : S_DONE;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.commit = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_out_tvalid = 1'b1;
                o_in_tready = i_out_tready;
                if (i_out_tready) begin
                    if (i_in_tvalid) begin
                        o_cmd.load = 1'b1;
                        n_state = S_EXEC;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// File: design/ppcex_dpath.sv
// datapath: register file, special registers, alu and serial divider
`timescale 1ns / 1ps
module ppcex_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [31:0]        i_instr,
    input  ppcex_pkg::t_cmd    i_cmd,
    output ppcex_pkg::t_status o_status,
    output logic [71:0]        o_result
);

    localparam int unsigned NREGS = ppcex_pkg::NREGS;
    localparam int unsigned IW = $clog2(NREGS);
    localparam logic [31:0] ALL_ONES_F = ppcex_pkg::ALL_ONES;

    // register file, cleared by a valid bit per entry
    logic [31:0]    r_gpr [NREGS];
    logic [NREGS-1:0] r_gpr_vld;
    logic [31:0] r_cr, r_xer, r_lr, r_ctr;

    logic [31:0] r_w, r_a, r_b, r_s;

    // pending result
    logic        r_ok, r_wr;
    logic [4:0]  r_widx;
    logic [31:0] r_val, r_ncr, r_nxer, r_nlr, r_nctr;
    logic        r_rc;

    // divider
    logic [31:0] r_dq, r_dr, r_dd;
    logic [5:0]  r_dcnt;
    logic        r_dneg, r_dsigned;

    // result output
    logic        r_o_st, r_o_dv;
    logic [4:0]  r_o_idx;
    logic [31:0] r_o_val;

    logic [5:0]  w_pri;
    logic [9:0]  w_xo;
    logic [4:0]  w_rd, w_ra, w_rb;
    logic [15:0] w_uimm;
    logic [31:0] w_imm;
    logic [9:0]  w_spr;
    logic [2:0]  w_crf;

    assign w_pri  = r_w[31:26];
    assign w_rd   = r_w[25:21];
    assign w_ra   = r_w[20:16];
    assign w_rb   = r_w[15:11];
    assign w_uimm = r_w[15:0];
    assign w_imm  = {{16{r_w[15]}}, r_w[15:0]};
    assign w_xo   = r_w[10:1];
    assign w_spr  = {w_rb, w_ra};
    assign w_crf  = r_w[25:23];

    function automatic logic [31:0] rd_gpr(input logic [IW-1:0] ix, input logic [NREGS-1:0] v,
                                           input logic [31:0] d);
        return v[ix] ? d : 32'd0;
    endfunction

    // combinational execution
    logic        c_ok, c_wr, c_arith, c_logic, c_rec, c_div;
    logic [4:0]  c_widx;
    logic [31:0] c_val, c_cr, c_xer, c_lr, c_ctr;
    logic [63:0] c_prod;
    logic [32:0] c_sum;
    logic [31:0] c_rot, c_mask, c_lo, c_hi, c_crm;
    logic [5:0]  c_n;
    logic [4:0]  c_sh;

    always_comb begin
        c_ok = 1'b1; c_wr = 1'b0; c_arith = 1'b0; c_logic = 1'b0; c_rec = 1'b0;
        c_div = 1'b0; c_widx = w_rd; c_val = '0;
        c_cr = r_cr; c_xer = r_xer; c_lr = r_lr; c_ctr = r_ctr;
        c_prod = '0; c_sum = '0; c_n = '0; c_crm = '0;
        c_sh = w_rb;
        c_rot = (r_s << c_sh) | ((c_sh == 5'd0) ? 32'd0 : (r_s >> (6'd32 - {1'b0, c_sh})));
        c_lo = ALL_ONES_F >> r_w[10:6];
        c_hi = ALL_ONES_F << (5'd31 - r_w[5:1]);
        c_mask = (r_w[10:6] <= r_w[5:1]) ? (c_lo & c_hi) : (c_lo | c_hi);
        if (w_pri == ppcex_pkg::OP_EXT) begin
            case (w_xo)
                ppcex_pkg::XO_ADD:  begin c_val = r_a + r_b; c_arith = 1'b1; end
                ppcex_pkg::XO_SUBF: begin c_val = r_b - r_a; c_arith = 1'b1; end
                ppcex_pkg::XO_MULLW: begin c_val = r_a * r_b; c_arith = 1'b1; end
                ppcex_pkg::XO_MULHW: begin
                    c_prod = $signed(r_a) * $signed(r_b);
                    c_val = c_prod[63:32]; c_arith = 1'b1;
                end
                ppcex_pkg::XO_MULHWU: begin
                    c_prod = r_a * r_b;
                    c_val = c_prod[63:32]; c_arith = 1'b1;
                end
                ppcex_pkg::XO_DIVW, ppcex_pkg::XO_DIVWU: begin
                    c_arith = 1'b1; c_div = 1'b1;
                end
                ppcex_pkg::XO_NEG:  begin c_val = 32'd0 - r_a; c_arith = 1'b1; end
                ppcex_pkg::XO_AND:  begin c_val = r_s & r_b; c_logic = 1'b1; end
                ppcex_pkg::XO_OR:   begin c_val = r_s | r_b; c_logic = 1'b1; end
                ppcex_pkg::XO_XOR:  begin c_val = r_s ^ r_b; c_logic = 1'b1; end
                ppcex_pkg::XO_NAND: begin c_val = ~(r_s & r_b); c_logic = 1'b1; end
                ppcex_pkg::XO_NOR:  begin c_val = ~(r_s | r_b); c_logic = 1'b1; end
                ppcex_pkg::XO_ANDC: begin c_val = r_s & ~r_b; c_logic = 1'b1; end
                ppcex_pkg::XO_ORC:  begin c_val = r_s | ~r_b; c_logic = 1'b1; end
                ppcex_pkg::XO_EQV:  begin c_val = ~(r_s ^ r_b); c_logic = 1'b1; end
                ppcex_pkg::XO_SLW: begin
                    c_val = r_b[5] ? 32'd0 : (r_s << r_b[4:0]); c_logic = 1'b1;
                end
                ppcex_pkg::XO_SRW: begin
                    c_val = r_b[5] ? 32'd0 : (r_s >> r_b[4:0]); c_logic = 1'b1;
                end
                ppcex_pkg::XO_SRAW: begin
                    c_logic = 1'b1;
                    if (r_b[5]) begin
                        c_val = {32{r_s[31]}};
                        c_xer[29] = r_s[31];
                    end else begin
                        c_val = 32'($signed(r_s) >>> r_b[4:0]);
                        c_xer[29] = r_s[31] && ((r_s & ~(ALL_ONES_F << r_b[4:0])) != 0);
                    end
                end
                ppcex_pkg::XO_SRAWI: begin
                    c_logic = 1'b1;
                    c_val = 32'($signed(r_s) >>> w_rb);
                    c_xer[29] = r_s[31] && ((r_s & ~(ALL_ONES_F << w_rb)) != 0);
                end
                ppcex_pkg::XO_EXTSB: begin c_val = {{24{r_s[7]}}, r_s[7:0]}; c_logic = 1'b1; end
                ppcex_pkg::XO_EXTSH: begin c_val = {{16{r_s[15]}}, r_s[15:0]}; c_logic = 1'b1; end
                ppcex_pkg::XO_CNTLZW: begin
                    c_n = 6'd32;
                    for (int i = 0; i < 32; i++) begin
                        if (r_s[i]) c_n = 6'(31 - i);
                    end
                    c_val = {26'd0, c_n}; c_logic = 1'b1;
                end
                ppcex_pkg::XO_CMP:
                    c_cr = ppcex_pkg::put_field(r_cr, w_crf,
                        ppcex_pkg::cmp_code(r_a, r_b, 1'b1, r_xer[31]));
                ppcex_pkg::XO_CMPL:
                    c_cr = ppcex_pkg::put_field(r_cr, w_crf,
                        ppcex_pkg::cmp_code(r_a, r_b, 1'b0, r_xer[31]));
                ppcex_pkg::XO_MFSPR: begin
                    c_wr = 1'b1;
                    c_val = (w_spr == ppcex_pkg::SPR_LR) ? r_lr :
                            (w_spr == ppcex_pkg::SPR_CTR) ? r_ctr :
                            (w_spr == ppcex_pkg::SPR_XER) ? r_xer : 32'd0;
                end
                ppcex_pkg::XO_MTSPR: begin
                    if (w_spr == ppcex_pkg::SPR_LR) c_lr = r_s;
                    else if (w_spr == ppcex_pkg::SPR_CTR) c_ctr = r_s;
                    else if (w_spr == ppcex_pkg::SPR_XER) c_xer = r_s;
                end
                ppcex_pkg::XO_MFCR: begin c_wr = 1'b1; c_val = r_cr; end
                ppcex_pkg::XO_MTCRF: begin
                    for (int i = 0; i < 8; i++) begin
                        c_crm[i*4 +: 4] = {4{r_w[12+i]}};
                    end
                    c_cr = (r_cr & ~c_crm) | (r_s & c_crm);
                end
                default: c_ok = 1'b0;
            endcase
            if (c_arith || c_logic) begin
                c_wr = 1'b1;
                c_widx = c_arith ? w_rd : w_ra;
                c_rec = r_w[0];
            end
        end else begin
            case (w_pri)
                ppcex_pkg::OP_ADDI: begin
                    c_val = ((w_ra != 5'd0) ? r_a : 32'd0) + w_imm; c_wr = 1'b1;
                end
                ppcex_pkg::OP_ADDIS: begin
                    c_val = ((w_ra != 5'd0) ? r_a : 32'd0) + {w_uimm, 16'd0}; c_wr = 1'b1;
                end
                ppcex_pkg::OP_MULLI: begin c_val = r_a * w_imm; c_wr = 1'b1; end
                ppcex_pkg::OP_ADDIC, ppcex_pkg::OP_ADDICR: begin
                    c_sum = {1'b0, r_a} + {1'b0, w_imm};
                    c_val = c_sum[31:0]; c_xer[29] = c_sum[32]; c_wr = 1'b1;
                    c_rec = (w_pri == ppcex_pkg::OP_ADDICR);
                end
                ppcex_pkg::OP_SUBFIC: begin
                    c_sum = {1'b0, w_imm} + {1'b0, ~r_a} + 33'd1;
                    c_val = c_sum[31:0]; c_xer[29] = c_sum[32]; c_wr = 1'b1;
                end
                ppcex_pkg::OP_CMPI:
                    c_cr = ppcex_pkg::put_field(r_cr, w_crf,
                        ppcex_pkg::cmp_code(r_a, w_imm, 1'b1, r_xer[31]));
                ppcex_pkg::OP_CMPLI:
                    c_cr = ppcex_pkg::put_field(r_cr, w_crf,
                        ppcex_pkg::cmp_code(r_a, {16'd0, w_uimm}, 1'b0, r_xer[31]));
                ppcex_pkg::OP_ORI: begin
                    c_val = r_s | {16'd0, w_uimm}; c_wr = 1'b1; c_widx = w_ra;
                end
                ppcex_pkg::OP_ORIS: begin
                    c_val = r_s | {w_uimm, 16'd0}; c_wr = 1'b1; c_widx = w_ra;
                end
                ppcex_pkg::OP_XORI: begin
                    c_val = r_s ^ {16'd0, w_uimm}; c_wr = 1'b1; c_widx = w_ra;
                end
                ppcex_pkg::OP_XORIS: begin
                    c_val = r_s ^ {w_uimm, 16'd0}; c_wr = 1'b1; c_widx = w_ra;
                end
                ppcex_pkg::OP_ANDI: begin
                    c_val = r_s & {16'd0, w_uimm}; c_wr = 1'b1; c_widx = w_ra; c_rec = 1'b1;
                end
                ppcex_pkg::OP_ANDIS: begin
                    c_val = r_s & {w_uimm, 16'd0}; c_wr = 1'b1; c_widx = w_ra; c_rec = 1'b1;
                end
                ppcex_pkg::OP_RLWINM: begin
                    c_val = c_rot & c_mask; c_wr = 1'b1; c_widx = w_ra; c_rec = r_w[0];
                end
                ppcex_pkg::OP_RLWIMI: begin
                    c_val = (c_rot & c_mask) | (r_a & ~c_mask); c_wr = 1'b1; c_widx = w_ra;
                    c_rec = r_w[0];
                end
                default: c_ok = 1'b0;
            endcase
        end
    end

    // divider inputs: magnitudes for signed divide
    logic        d_sgn, d_neg, d_zero, d_ovf;
    logic [31:0] d_num, d_den;
    assign d_sgn  = (w_xo == ppcex_pkg::XO_DIVW);
    assign d_num  = (d_sgn && r_a[31]) ? (32'd0 - r_a) : r_a;
    assign d_den  = (d_sgn && r_b[31]) ? (32'd0 - r_b) : r_b;
    assign d_neg  = d_sgn && (r_a[31] ^ r_b[31]);
    assign d_zero = (r_b == 32'd0);
    assign d_ovf  = d_sgn && (r_a == ppcex_pkg::SO_BIT) && (r_b == ppcex_pkg::ALL_ONES);

    // one restoring step, partial remainder kept to 33 bits
    logic [32:0] d_trial;
    logic [32:0] d_rem_sh;
    assign d_rem_sh = {r_dr, r_dq[31]};
    assign d_trial  = d_rem_sh - {1'b0, r_dd};

    // final value with divide result folded in
    logic [31:0] f_val, f_cr;
    always_comb begin
        f_val = r_val;
        if (r_dsigned) begin
            f_val = r_dneg ? (32'd0 - r_dq) : r_dq;
        end
        f_cr = r_ncr;
        if (r_rc) begin
            f_cr = ppcex_pkg::put_field(r_ncr, 3'd0,
                ppcex_pkg::cmp_code(f_val, 32'd0, 1'b1, r_nxer[31]));
        end
    end

    assign o_status.is_div   = c_div && c_ok;
    assign o_status.div_done = (r_dcnt == 6'd1);

    // control state of datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gpr_vld <= '0;
            r_cr <= '0; r_xer <= '0; r_lr <= '0; r_ctr <= '0;
            r_dcnt <= '0;
            r_dsigned <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_dcnt <= c_div ? 6'd32 : 6'd0;
                r_dsigned <= c_div && !d_zero && !d_ovf;
            end else if (i_cmd.div_step && r_dcnt != 6'd0) begin
                r_dcnt <= r_dcnt - 6'd1;
            end
            if (i_cmd.commit && r_ok) begin
                if (r_wr) r_gpr_vld[r_widx[IW-1:0]] <= 1'b1;
                r_cr <= f_cr; r_xer <= r_nxer; r_lr <= r_nlr; r_ctr <= r_nctr;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_w <= i_instr;
            r_a <= rd_gpr(i_instr[16 +: IW], r_gpr_vld, r_gpr[i_instr[16 +: IW]]);
            r_b <= rd_gpr(i_instr[11 +: IW], r_gpr_vld, r_gpr[i_instr[11 +: IW]]);
            r_s <= rd_gpr(i_instr[21 +: IW], r_gpr_vld, r_gpr[i_instr[21 +: IW]]);
        end
        if (i_cmd.exec) begin
            r_ok <= c_ok; r_wr <= c_wr && c_ok; r_widx <= c_widx;
            r_val <= (c_div && d_ovf) ? ppcex_pkg::SO_BIT : c_val;
            r_ncr <= c_cr; r_nxer <= c_xer; r_nlr <= c_lr; r_nctr <= c_ctr;
            r_rc <= c_rec;
            r_dq <= d_num; r_dr <= '0; r_dd <= d_den; r_dneg <= d_neg;
        end else if (i_cmd.div_step && r_dcnt != 6'd0) begin
            if (!d_trial[32]) begin
                r_dr <= d_trial[31:0];
                r_dq <= {r_dq[30:0], 1'b1};
            end else begin
                r_dr <= d_rem_sh[31:0];
                r_dq <= {r_dq[30:0], 1'b0};
            end
        end
        if (i_cmd.commit) begin
            if (r_ok && r_wr) r_gpr[r_widx[IW-1:0]] <= f_val;
            r_o_st  <= !r_ok;
            r_o_dv  <= r_ok && r_wr;
            r_o_idx <= (r_ok && r_wr) ? r_widx : 5'd0;
            r_o_val <= (r_ok && r_wr) ? f_val : 32'd0;
        end
    end

    // packed result: status, dest_valid, dest_index, dest_value, cond_reg, carry_flag
    assign o_result = {r_xer[29], r_cr, r_o_val, r_o_idx, r_o_dv, r_o_st};

endmodule
